// File: hw/rtl/amc_pkg.sv
`timescale 1ns / 1ps

package amc_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [1:0] KIND_INSTR = 2'd0;
    localparam logic [1:0] KIND_MARK  = 2'd1;
    localparam logic [1:0] KIND_LIT   = 2'd2;

    localparam logic [1:0] SPLIT_NONE = 2'd0;
    localparam logic [1:0] SPLIT_ONE  = 2'd1;
    localparam logic [1:0] SPLIT_TWO  = 2'd2;

    localparam logic [31:0] OP_MOV    = 32'he3a00000;
    localparam logic [31:0] OP_MVN    = 32'he3e00000;
    localparam logic [31:0] OP_ORR    = 32'he3800000;
    localparam logic [31:0] OP_BIC    = 32'he3c00000;
    localparam logic [31:0] OP_LDR_PC = 32'he59f0000;
    localparam logic [31:0] POOL_MARK = 32'hff000000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] value;
        logic [3:0]  dest_reg;
    } t_in_item;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  word_kind;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic write;
    } t_cell_ctrl;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] a;
        logic [11:0] b;
    } t_split;

    typedef struct packed {
        logic [31:0] t;
        logic [3:0]  rot;
    } t_norm;

    function automatic t_norm amc_normalize(logic [31:0] t, logic [3:0] rot);
        t_norm res;
        res.t   = t;
        res.rot = rot;
        for (int s = 0; s < 3; s++) begin
            if (res.t != 32'd0 && res.t[31:24] == 8'd0) begin
                res.t   = {res.t[23:0], 8'd0};
                res.rot = res.rot + 4'd4;
            end
        end
        if (res.t != 32'd0 && res.t[31:28] == 4'd0) begin
            res.t   = {res.t[27:0], 4'd0};
            res.rot = res.rot + 4'd2;
        end
        if (res.t != 32'd0 && res.t[31:30] == 2'd0) begin
            res.t   = {res.t[29:0], 2'd0};
            res.rot = res.rot + 4'd1;
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/amc_cell.sv
`timescale 1ns / 1ps

module amc_cell (
    input  logic                i_clk,
    input  amc_pkg::t_cell_ctrl i_ctrl,
    input  logic [31:0]         i_value,
    input  logic [31:0]         i_next,
    output logic [31:0]         o_entry,
    output logic                o_eq
);
    import amc_pkg::*;

    logic [31:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.write) begin
            r_entry <= i_value;
        end else if (i_ctrl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_eq    = (r_entry == i_value);

endmodule

// File: hw/rtl/amc_split.sv
`timescale 1ns / 1ps

module amc_split (
    input  logic            i_clk,
    input  logic [31:0]     i_t,
    output amc_pkg::t_split o_split
);
    import amc_pkg::*;

    t_norm  r_n1;
    t_split r_split;
    t_norm  w_n1;
    t_norm  w_n2;
    t_split w_split;

    assign w_n1 = amc_normalize(i_t, 4'd0);
    assign w_n2 = amc_normalize({r_n1.t[23:0], 8'd0}, r_n1.rot + 4'd4);

    always_comb begin
        w_split.kind = SPLIT_NONE;
        w_split.a    = {r_n1.rot, r_n1.t[31:24]};
        w_split.b    = {w_n2.rot, w_n2.t[31:24]};
        if (r_n1.t[23:0] == 24'd0) begin
            w_split.kind = SPLIT_ONE;
        end else if (w_n2.t[23:0] == 24'd0) begin
            w_split.kind = SPLIT_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n1    <= w_n1;
        r_split <= w_split;
    end

    assign o_split = r_split;

endmodule

// File: hw/rtl/arm_immediate_materializer.sv
`timescale 1ns / 1ps

// Turns a 32-bit constant into the ARM words that load it into a register: MOV or MVN with
// a rotated 8-bit immediate, a MOV/ORR or MVN/BIC pair, or a PC-relative LDR from a
// deduplicating literal pool of POOL_DEPTH entries held in a row of cells. A load goes
// through the two-stage split units and the decision step, then its words go out in
// order as the output register frees; a pool dump (on a flush of a non-empty pool, or
// when a new literal finds the pool full) sends a marker, then each entry as cells shift
// to the head. The next item is accepted once the last word sits in the output register.
module arm_immediate_materializer #(
    parameter int POOL_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  amc_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output amc_pkg::t_out_item o_out
);
    import amc_pkg::*;

    localparam int FW = $clog2(POOL_DEPTH + 1);
    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM1,
        S_NORM2,
        S_DECIDE,
        S_EMIT1,
        S_EMIT2,
        S_MARK,
        S_DUMP,
        S_LDR
    } t_state;

    t_state      r_state, n_state;
    logic        r_cmd, n_cmd;
    logic [31:0] r_value, n_value;
    logic [3:0]  r_rd, n_rd;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_cnt, n_cnt;
    logic        r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [31:0] r_w1, n_w1;
    logic [31:0] r_w2, n_w2;
    logic        r_two, n_two;
    logic        r_flush, n_flush;
    logic        r_append, n_append;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic          w_out_free;
    logic          w_shift;
    logic          w_append;
    logic          w_hit;
    logic [IW-1:0] w_hit_idx;
    logic [IW-1:0] w_ldr_idx;
    logic [31:0]   w_rimm;
    logic [31:0]   w_rd_lo;
    logic [31:0]   w_rd_hi;
    t_split        w_sp;
    t_split        w_sn;
    logic [31:0]   w_entry [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] w_eq;
    logic [POOL_DEPTH-1:0] w_match;

    assign w_rimm  = {r_value[7:0], r_value[31:8]};
    assign w_rd_lo = 32'(r_rd) << 12;
    assign w_rd_hi = 32'(r_rd) << 16;

    amc_split u_split_pos (
        .i_clk   (i_clk),
        .i_t     (w_rimm),
        .o_split (w_sp)
    );

    amc_split u_split_neg (
        .i_clk   (i_clk),
        .i_t     (~w_rimm),
        .o_split (w_sn)
    );

    for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
        t_cell_ctrl  w_ctrl;
        logic [31:0] w_next;

        assign w_ctrl.shift = w_shift;
        assign w_ctrl.write = w_append && (r_fill == FW'(g));
        if (g + 1 < POOL_DEPTH) begin : g_mid
            assign w_next = w_entry[g + 1];
        end else begin : g_end
            assign w_next = 32'd0;
        end

        amc_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_value (r_value),
            .i_next  (w_next),
            .o_entry (w_entry[g]),
            .o_eq    (w_eq[g])
        );

        assign w_match[g] = w_eq[g] && (FW'(g) < r_fill);
    end

    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit     = 1'b1;
                w_hit_idx = IW'(i);
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_ldr_idx  = r_append ? r_fill[IW-1:0] : r_hit_idx;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_value     = r_value;
        n_rd        = r_rd;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_two       = r_two;
        n_flush     = r_flush;
        n_append    = r_append;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_shift     = 1'b0;
        w_append    = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in.cmd;
                    n_value = i_in.value;
                    n_rd    = i_in.dest_reg;
                    n_state = S_NORM1;
                end
            end
            S_NORM1: begin
                n_hit     = w_hit;
                n_hit_idx = w_hit_idx;
                n_state   = S_NORM2;
            end
            S_NORM2: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_cmd == CMD_FLUSH) begin
                    n_flush = 1'b1;
                    n_state = (r_fill == '0) ? S_IDLE : S_MARK;
                end else if (w_sp.kind != SPLIT_NONE) begin
                    n_w1    = OP_MOV | w_rd_lo | 32'(w_sp.a);
                    n_w2    = OP_ORR | w_rd_hi | w_rd_lo | 32'(w_sp.b);
                    n_two   = (w_sp.kind == SPLIT_TWO);
                    n_state = S_EMIT1;
                end else if (w_sn.kind != SPLIT_NONE) begin
                    n_w1    = OP_MVN | w_rd_lo | 32'(w_sn.a);
                    n_w2    = OP_BIC | w_rd_hi | w_rd_lo | 32'(w_sn.b);
                    n_two   = (w_sn.kind == SPLIT_TWO);
                    n_state = S_EMIT1;
                end else if (r_hit) begin
                    n_append = 1'b0;
                    n_state  = S_LDR;
                end else begin
                    n_append = 1'b1;
                    n_flush  = 1'b0;
                    n_state  = (r_fill == FW'(POOL_DEPTH)) ? S_MARK : S_LDR;
                end
            end
            S_EMIT1: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{word: r_w1, word_kind: KIND_INSTR, last: !r_two};
                    n_state     = r_two ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{word: r_w2, word_kind: KIND_INSTR, last: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_MARK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{word: POOL_MARK | 32'(r_fill), word_kind: KIND_MARK,
                                    last: 1'b0};
                    n_cnt       = '0;
                    n_state     = S_DUMP;
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_shift     = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '{word: w_entry[0], word_kind: KIND_LIT,
                                    last: r_flush && (r_cnt == r_fill - 1'b1)};
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == r_fill - 1'b1) begin
                        n_fill  = '0;
                        n_state = r_flush ? S_IDLE : S_LDR;
                    end
                end
            end
            S_LDR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{word: OP_LDR_PC | w_rd_lo | 32'({w_ldr_idx, 2'b00}),
                                    word_kind: KIND_INSTR, last: 1'b1};
                    if (r_append) begin
                        w_append = 1'b1;
                        n_fill   = r_fill + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_value   <= n_value;
        r_rd      <= n_rd;
        r_cnt     <= n_cnt;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_w1      <= n_w1;
        r_w2      <= n_w2;
        r_two     <= n_two;
        r_flush   <= n_flush;
        r_append  <= n_append;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(POOL_DEPTH))
        else $error("pool fill exceeds pool depth");

    a_hit_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_hit) |-> (FW'(r_hit_idx) < r_fill))
        else $error("pool hit index outside filled entries");

    a_dump_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LDR && $past(r_state) == S_DUMP) |-> (r_fill == '0))
        else $error("pool not empty after dump");

    a_mark_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.word_kind == KIND_MARK) |-> !r_out.last)
        else $error("pool marker flagged as last word");

    a_dump_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_cnt < r_fill))
        else $error("dump count runs past pool fill");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import amc_pkg::*;

    localparam int POOL_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 334;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PRINT_LIMIT  = 50;

    typedef struct {
        t_in_item    item;
        bit          typed;
        int          typed_n;
        logic [31:0] typed_word;
    } t_stim_row;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    logic        row_typed;
    int          row_n;
    logic [31:0] row_word;

    logic [31:0] lit_pool [POOL_DEPTH];
    int          lit_fill = 0;
    t_out_item   words_due [$];
    t_out_item   discard_q [$];
    logic [31:0] recent_lits [$];

    int  errors      = 0;
    int  items_taken = 0;
    int  words_seen  = 0;
    int  instr_words = 0;
    int  pool_dumps  = 0;
    int  lit_words   = 0;
    int  cycles      = 0;
    bit  idle_send   = 1'b1;
    bit  idle_recv   = 1'b1;

    arm_immediate_materializer #(
        .POOL_DEPTH(POOL_DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_out_item mk_word(logic [31:0] w, logic [1:0] kind);
        t_out_item r;
        r.word      = w;
        r.word_kind = kind;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic void normalize_imm(inout logic [31:0] t, inout logic [3:0] rot);
        while (t != 32'd0 && t[31:24] == 8'd0) begin
            t   = t << 8;
            rot = rot + 4'd4;
        end
        if (t != 32'd0 && t[31:28] == 4'd0) begin
            t   = t << 4;
            rot = rot + 4'd2;
        end
        if (t != 32'd0 && t[31:30] == 2'd0) begin
            t   = t << 2;
            rot = rot + 4'd1;
        end
    endfunction

    function automatic logic [1:0] split_imm(input logic [31:0] t, output logic [11:0] a,
                                             output logic [11:0] b);
        logic [3:0] r1;
        logic [3:0] r2;
        logic [7:0] lead_byte;
        r1 = 4'd0;
        a  = 12'd0;
        b  = 12'd0;
        normalize_imm(t, r1);
        if (t[23:0] == 24'd0) begin
            a = {r1, t[31:24]};
            return SPLIT_ONE;
        end
        lead_byte = t[31:24];
        r2        = r1 + 4'd4;
        t         = t << 8;
        normalize_imm(t, r2);
        if (t[23:0] == 24'd0) begin
            a = {r1, lead_byte};
            b = {r2, t[31:24]};
            return SPLIT_TWO;
        end
        return SPLIT_NONE;
    endfunction

    function automatic void dump_literals(ref t_out_item q[$]);
        if (lit_fill == 0) return;
        q.push_back(mk_word(POOL_MARK | 32'(lit_fill), KIND_MARK));
        for (int i = 0; i < lit_fill; i++) q.push_back(mk_word(lit_pool[i], KIND_LIT));
        lit_fill = 0;
    endfunction

    function automatic void materialize(input t_in_item it, ref t_out_item q[$]);
        logic [31:0] rimm;
        logic [31:0] rd_lo;
        logic [31:0] rd_hi;
        logic [11:0] a;
        logic [11:0] b;
        logic [1:0]  k;
        int          idx;
        int          n0;
        n0    = q.size();
        rd_lo = {16'h0, it.dest_reg, 12'h0};
        rd_hi = {12'h0, it.dest_reg, 16'h0};
        if (it.cmd == CMD_FLUSH) begin
            dump_literals(q);
        end else begin
            rimm = {it.value[7:0], it.value[31:8]};
            k    = split_imm(rimm, a, b);
            if (k != SPLIT_NONE) begin
                q.push_back(mk_word(OP_MOV | rd_lo | 32'(a), KIND_INSTR));
                if (k == SPLIT_TWO)
                    q.push_back(mk_word(OP_ORR | rd_hi | rd_lo | 32'(b), KIND_INSTR));
            end else begin
                k = split_imm(~rimm, a, b);
                if (k != SPLIT_NONE) begin
                    q.push_back(mk_word(OP_MVN | rd_lo | 32'(a), KIND_INSTR));
                    if (k == SPLIT_TWO)
                        q.push_back(mk_word(OP_BIC | rd_hi | rd_lo | 32'(b), KIND_INSTR));
                end else begin
                    idx = -1;
                    for (int i = 0; i < lit_fill; i++)
                        if (idx < 0 && lit_pool[i] == it.value) idx = i;
                    if (idx < 0) begin
                        if (lit_fill >= POOL_DEPTH) dump_literals(q);
                        idx           = lit_fill;
                        lit_pool[idx] = it.value;
                        lit_fill++;
                    end
                    q.push_back(mk_word(OP_LDR_PC | rd_lo | (32'(idx) << 2), KIND_INSTR));
                end
            end
        end
        if (q.size() > n0) q[q.size() - 1].last = 1'b1;
    endfunction

    function automatic t_stim_row mk_row(logic cmd, logic [31:0] v, logic [3:0] rd, bit typed,
                                         int n, logic [31:0] w);
        t_stim_row r;
        r.item.cmd      = cmd;
        r.item.value    = v;
        r.item.dest_reg = rd;
        r.typed         = typed;
        r.typed_n       = n;
        r.typed_word    = w;
        return r;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       pick;
        it.cmd      = CMD_LOAD;
        it.value    = $urandom;
        it.dest_reg = 4'($urandom_range(0, 15));
        pick        = $urandom_range(0, 99);
        if (pick < 8) begin
            it.cmd = CMD_FLUSH;
        end else if (pick < 28) begin
            it.value = ror32(32'($urandom_range(0, 255)), 2 * $urandom_range(0, 15));
        end else if (pick < 46) begin
            it.value = ror32(32'($urandom_range(1, 255)), 2 * $urandom_range(0, 15))
                     | ror32(32'($urandom_range(1, 255)), 2 * $urandom_range(0, 15));
        end else if (pick < 52) begin
            case ($urandom_range(0, 3))
                0: it.value = 32'h00000000;
                1: it.value = 32'hffffffff;
                2: it.value = 32'h80000000;
                default: it.value = 32'h00000001;
            endcase
        end else if (pick < 70 && recent_lits.size() != 0) begin
            it.value = recent_lits[$urandom_range(0, recent_lits.size() - 1)];
        end else begin
            recent_lits.push_back(it.value);
            if (recent_lits.size() > 24) void'(recent_lits.pop_front());
        end
        if (pick >= 8 && pick < 46 && $urandom_range(0, 1) == 1) it.value = ~it.value;
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("MISMATCH at %0t, word %0d: %s got %h want %h",
                     $time, words_seen, what, got, want);
    endtask

    task automatic push_item(t_stim_row r);
        in_item   <= r.item;
        row_typed <= r.typed;
        row_n     <= r.typed_n;
        row_word  <= r.typed_word;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (idle_send && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        t_out_item want;
        t_out_item typed_word;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                items_taken++;
                if (row_typed) begin
                    discard_q = {};
                    materialize(in_item, discard_q);
                    if (row_n != 0) begin
                        typed_word      = mk_word(row_word, KIND_INSTR);
                        typed_word.last = 1'b1;
                        words_due.push_back(typed_word);
                    end
                end else begin
                    materialize(in_item, words_due);
                end
            end
            if (out_valid && out_ready) begin
                words_seen++;
                case (out_item.word_kind)
                    KIND_MARK: pool_dumps++;
                    KIND_LIT:  lit_words++;
                    default:   instr_words++;
                endcase
                if (words_due.size() == 0) begin
                    report_mismatch("word with none expected", out_item.word, 32'd0);
                end else begin
                    want = words_due.pop_front();
                    if (out_item.word != want.word)
                        report_mismatch("word", out_item.word, want.word);
                    if (out_item.word_kind != want.word_kind)
                        report_mismatch("word_kind", 32'(out_item.word_kind),
                                        32'(want.word_kind));
                    if (out_item.last != want.last)
                        report_mismatch("last", 32'(out_item.last), 32'(want.last));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, words_due.size());
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (idle_recv && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial begin
        t_stim_row rows [$];
        t_stim_row row;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        row_typed <= 1'b0;
        row_n     <= 0;
        row_word  <= '0;

        rows.push_back(mk_row(CMD_FLUSH, 32'hffffffff, 4'hf, 1'b1, 0, 32'd0));
        rows.push_back(mk_row(CMD_LOAD, 32'h00000000, 4'h0, 1'b1, 1, OP_MOV));
        rows.push_back(mk_row(CMD_LOAD, 32'hffffffff, 4'hf, 1'b1, 1, OP_MVN | 32'h0000f000));
        rows.push_back(mk_row(CMD_LOAD, 32'h000000ff, 4'h9, 1'b1, 1, OP_MOV | 32'h000090ff));
        rows.push_back(mk_row(CMD_LOAD, 32'h00ff00ff, 4'h3, 1'b0, 0, 32'd0));
        rows.push_back(mk_row(CMD_LOAD, 32'hffffff00, 4'h5, 1'b0, 0, 32'd0));
        rows.push_back(mk_row(CMD_LOAD, 32'hfff0f0ff, 4'hc, 1'b0, 0, 32'd0));
        rows.push_back(mk_row(CMD_LOAD, 32'h12345678, 4'h0, 1'b1, 1, OP_LDR_PC));
        rows.push_back(mk_row(CMD_LOAD, 32'h12345678, 4'he, 1'b0, 0, 32'd0));
        for (int i = 1; i < POOL_DEPTH; i++)
            rows.push_back(mk_row(CMD_LOAD, 32'h13579bd0 + 32'(i), 4'(i), 1'b0, 0, 32'd0));
        rows.push_back(mk_row(CMD_LOAD, 32'h2468ace1, 4'h7, 1'b0, 0, 32'd0));
        rows.push_back(mk_row(CMD_FLUSH, 32'h0, 4'h0, 1'b0, 0, 32'd0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            maybe_gap();
            push_item(rows[i]);
        end
        hold_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) begin
                idle_send = ($urandom_range(0, 3) != 0);
                idle_recv = ($urandom_range(0, 3) != 0);
            end
            if (i >= RANDOM_ITEMS - 60) begin
                idle_send = 1'b0;
                idle_recv = 1'b0;
            end
            if (i == RANDOM_ITEMS / 2) hold_until_drained();
            maybe_gap();
            row       = mk_row(CMD_LOAD, 32'd0, 4'd0, 1'b0, 0, 32'd0);
            row.item  = rand_item();
            push_item(row);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items and %0d words out: %0d instructions,",
                 items_taken, words_seen, instr_words);
        $display("%0d pool dumps carrying %0d literals; %0d mismatches.",
                 pool_dumps, lit_words, errors);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
